[src/nir_pkg.sv]
// ----------------------------------------------------------------------------
// nir_pkg: shared types and constants of the NEC interval decoder
// Holds the mode encoding, event kinds, register indexes, register reset
// values and the configuration bundle passed from the register file.
// ----------------------------------------------------------------------------
package nir_pkg;

   // Widths fixed by the interface fields.
   localparam int unsigned TIME_W  = 17;
   localparam int unsigned CODE_W  = 32;
   localparam int unsigned INDEX_W = 3;

   // Decoder modes.
   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_DATA     = 2'd1,
      MODE_REP_GAP  = 2'd2,
      MODE_REP_LEAD = 2'd3
   } mode_type;

   // Event kinds carried with each result.
   localparam logic EVENT_NEW    = 1'b0;
   localparam logic EVENT_REPEAT = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [INDEX_W-1:0] REG_LEADER_MIN   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_LEADER_MAX   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_ONE_THRESH   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_REP_GAP_MIN  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_REP_GAP_MAX  = 3'd4;
   localparam logic [INDEX_W-1:0] REG_REP_LEAD_MIN = 3'd5;
   localparam logic [INDEX_W-1:0] REG_REP_LEAD_MAX = 3'd6;

   // Register values after reset, in microseconds.
   localparam logic [TIME_W-1:0] RST_LEADER_MIN   = TIME_W'(12 * 1000);
   localparam logic [TIME_W-1:0] RST_LEADER_MAX   = TIME_W'(15 * 1000);
   localparam logic [TIME_W-1:0] RST_ONE_THRESH   = TIME_W'(1650);
   localparam logic [TIME_W-1:0] RST_REP_GAP_MIN  = TIME_W'(20 * 1000);
   localparam logic [TIME_W-1:0] RST_REP_GAP_MAX  = TIME_W'(130 * 1000);
   localparam logic [TIME_W-1:0] RST_REP_LEAD_MIN = TIME_W'(9 * 1000);
   localparam logic [TIME_W-1:0] RST_REP_LEAD_MAX = TIME_W'(135 * 100);

   // Timing windows handed from the register file to the decoder.
   typedef struct packed {
      logic [TIME_W-1:0] leader_min;
      logic [TIME_W-1:0] leader_max;
      logic [TIME_W-1:0] one_thresh;
      logic [TIME_W-1:0] rep_gap_min;
      logic [TIME_W-1:0] rep_gap_max;
      logic [TIME_W-1:0] rep_lead_min;
      logic [TIME_W-1:0] rep_lead_max;
   } cfg_type;

endpackage

[src/nir_csr.sv]
// ----------------------------------------------------------------------------
// nir_csr: configuration register file
// Seven 17-bit timing registers written over a valid/ready port. Writes to
// an index beyond the list are taken and ignored.
// ----------------------------------------------------------------------------
module nir_csr
   import nir_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]  csr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // The register file takes a write in every cycle.
   assign csr_ready = 1'b1;

   // Select the register addressed by a transfer.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LEADER_MIN:   cfg_in.leader_min   = csr_data;
            REG_LEADER_MAX:   cfg_in.leader_max   = csr_data;
            REG_ONE_THRESH:   cfg_in.one_thresh   = csr_data;
            REG_REP_GAP_MIN:  cfg_in.rep_gap_min  = csr_data;
            REG_REP_GAP_MAX:  cfg_in.rep_gap_max  = csr_data;
            REG_REP_LEAD_MIN: cfg_in.rep_lead_min = csr_data;
            REG_REP_LEAD_MAX: cfg_in.rep_lead_max = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers load their documented values at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min   <= RST_LEADER_MIN;
         cfg_ff.leader_max   <= RST_LEADER_MAX;
         cfg_ff.one_thresh   <= RST_ONE_THRESH;
         cfg_ff.rep_gap_min  <= RST_REP_GAP_MIN;
         cfg_ff.rep_gap_max  <= RST_REP_GAP_MAX;
         cfg_ff.rep_lead_min <= RST_REP_LEAD_MIN;
         cfg_ff.rep_lead_max <= RST_REP_LEAD_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/nir_decode.sv]
// ----------------------------------------------------------------------------
// nir_decode: interval register, mode machine and result register
// An accepted interval is held in the input register, classified against
// the timing windows in one pass, and any event lands in the result register.
// ----------------------------------------------------------------------------
module nir_decode
   import nir_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [TIME_W-1:0] req_interval_us,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_event_kind,
   output logic [CODE_W-1:0] rsp_code_word
);

   localparam int unsigned CNT_W = $clog2(FRAME_BITS);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

   // Input register.
   logic              in_vld_ff, in_vld_in;
   logic [TIME_W-1:0] in_time_ff;

   // Decoder state.
   mode_type              mode_ff, mode_in;
   logic [CNT_W-1:0]      bits_ff, bits_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [FRAME_BITS-1:0] last_ff, last_in;

   // Result register.
   logic              out_vld_ff, out_vld_in;
   logic              out_kind_ff, out_kind_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;

   logic emit;
   logic out_free;
   logic fire;
   logic in_leader, in_gap, in_lead, is_one;
   logic [FRAME_BITS-1:0] shift_set;

   // Window checks on the held interval; bounds are exclusive.
   assign in_leader = (in_time_ff > cfg.leader_min) && (in_time_ff < cfg.leader_max);
   assign in_gap    = (in_time_ff > cfg.rep_gap_min) && (in_time_ff < cfg.rep_gap_max);
   assign in_lead   = (in_time_ff > cfg.rep_lead_min) && (in_time_ff < cfg.rep_lead_max);
   assign is_one    = in_time_ff > cfg.one_thresh;

   // Shift word with the current data bit placed at its position.
   always_comb begin
      for (int i = 0; i < FRAME_BITS; i++) begin
         shift_set[i] = shift_ff[i] | (is_one && (bits_ff == CNT_W'(i)));
      end
   end

   // Next state and any event for the held interval.
   always_comb begin
      mode_in     = mode_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      last_in     = last_ff;
      emit        = 1'b0;
      out_kind_in = EVENT_NEW;
      out_code_in = CODE_W'(last_ff);
      unique case (mode_ff)
         MODE_DATA: begin
            if (bits_ff == LAST_BIT) begin
               last_in     = shift_set;
               shift_in    = '0;
               bits_in     = '0;
               mode_in     = MODE_REP_GAP;
               emit        = 1'b1;
               out_kind_in = EVENT_NEW;
               out_code_in = CODE_W'(shift_set);
            end else begin
               shift_in = shift_set;
               bits_in  = bits_ff + CNT_W'(1);
            end
         end
         MODE_REP_GAP: begin
            if (in_gap) begin
               mode_in = MODE_REP_LEAD;
            end else if (in_leader) begin
               mode_in = MODE_DATA;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_REP_LEAD: begin
            if (in_lead) begin
               mode_in     = MODE_REP_GAP;
               emit        = 1'b1;
               out_kind_in = EVENT_REPEAT;
            end else if (in_leader) begin
               mode_in = MODE_DATA;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_IDLE: begin
            if (in_leader) begin
               mode_in  = MODE_DATA;
               bits_in  = '0;
               shift_in = '0;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   // An interval is consumed unless its event finds the result slot taken.
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && (!emit || out_free);
   assign req_stall = in_vld_ff && !fire;

   assign in_vld_in  = (req_valid && !req_stall) || (in_vld_ff && !fire);
   assign out_vld_in = (fire && emit) || (out_vld_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_time_ff <= req_interval_us;
      end
   end

   // Mode register and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         bits_ff  <= '0;
         shift_ff <= '0;
         last_ff  <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         last_ff  <= last_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_kind_ff <= out_kind_in;
         out_code_ff <= out_code_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_code_word  = out_code_ff;

   // A decoded frame always leaves the block waiting for a repeat gap.
   a_new_code_mode: assert property (@(posedge clock) disable iff (reset)
      (fire && emit && (out_kind_in == EVENT_NEW)) |=> (mode_ff == MODE_REP_GAP))
      else $error("new code did not enter repeat gap mode");

   // Outside a frame the bit count and shift word are clear.
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_DATA) |-> ((bits_ff == '0) && (shift_ff == '0)))
      else $error("frame state not clear outside data mode");

   // A held interval is not overwritten before it is consumed.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !fire) |=> (in_vld_ff && $stable(in_time_ff)))
      else $error("held interval lost");

   // An event is only written when the result slot can take it.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (fire && emit) |-> out_free)
      else $error("result register overrun");

endmodule

[src/nec_ir_interval_decoder_core.sv]
// ----------------------------------------------------------------------------
// nec_ir_interval_decoder_core: NEC infrared decoder on edge intervals
// Takes falling-edge intervals in microseconds and reports decoded codes
// and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one interval per transfer (req_valid high, req_stall low).
//   rsp_*  carries one event per transfer: rsp_event_kind is 0 for a newly
//          decoded code and 1 for a repeat of the last code; rsp_code_word
//          holds the code, bit i taken from data interval i.
//   csr_*  writes the seven timing windows; csr_ready is always high and a
//          write to an index past the list is ignored. Write only when idle.
// Path: an accepted interval is held in the input register and its event is
//   written to the result register, which drives rsp_valid; an event that
//   finds the result slot taken waits in the input register first.
// Throughput: one interval per cycle while no event waits on a taken result
//   slot, set by the single-pass compare and shift between the input register and the result register.
// Reset: synchronous; the decoder returns to idle with a cleared code and
//   the windows take their default NEC timings. No clearing pass is needed.
// Stall: while a result waits under rsp_stall, intervals that raise no
//   event keep flowing; one that raises an event waits in the input
//   register and req_stall is raised until the result is taken.
// ----------------------------------------------------------------------------
module nec_ir_interval_decoder_core
   import nir_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [TIME_W-1:0]  req_interval_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_event_kind,
   output logic [CODE_W-1:0]  rsp_code_word,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]  csr_data
);

   cfg_type cfg;

   // Timing window registers.
   nir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Interval classification and frame assembly.
   nir_decode #(
      .FRAME_BITS (FRAME_BITS)
   ) u_decode (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_interval_us (req_interval_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_code_word   (rsp_code_word)
   );

endmodule

[test/nec_ir_interval_decoder_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_interval_decoder_checker: event predictor and scoreboard
// Watches the interval, event and register channels of the NEC interval
// decoder. It keeps its own copy of the timing windows and decoder state,
// works out the event due for every interval transfer, and compares each
// event transfer field by field against the oldest event still owed.
// ----------------------------------------------------------------------------
module nec_ir_interval_decoder_checker
   import nir_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [TIME_W-1:0]  req_interval_us,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_event_kind,
   input  logic [CODE_W-1:0]  rsp_code_word,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]  csr_data,
   input  logic               run_done,
   output int unsigned        events_owed,
   output int unsigned        fail_count
);

   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] code;
   } ir_event_type;

   ir_event_type      owed_events[$];
   cfg_type           windows;
   mode_type          mode;
   logic [5:0]        bit_count;
   logic [CODE_W-1:0] shift_bits;
   logic [CODE_W-1:0] last_word;
   int unsigned       error_count = 0;

   function automatic bit in_window(input logic [TIME_W-1:0] t,
                                    input logic [TIME_W-1:0] lo,
                                    input logic [TIME_W-1:0] hi);
      return (t > lo) && (t < hi);
   endfunction

   // A failed repeat check falls back to idle, where the same interval may
   // open a new frame straight away.
   function automatic void enter_leader(input logic [TIME_W-1:0] t);
      mode = MODE_IDLE;
      if (in_window(t, windows.leader_min, windows.leader_max)) begin
         mode       = MODE_DATA;
         bit_count  = '0;
         shift_bits = '0;
      end
   endfunction

   // Advances the predicted decoder by one interval; returns 1 when the
   // interval raises an event.
   function automatic bit decode_interval(input logic [TIME_W-1:0] t,
                                          output ir_event_type ev);
      ev = '0;
      unique case (mode)
         MODE_DATA: begin
            if (t > windows.one_thresh && bit_count < 6'd32) begin
               shift_bits[bit_count[4:0]] = 1'b1;
            end
            bit_count = bit_count + 6'd1;
            if (bit_count >= FRAME_BITS) begin
               last_word  = shift_bits;
               shift_bits = '0;
               bit_count  = '0;
               mode       = MODE_REP_GAP;
               ev.kind    = EVENT_NEW;
               ev.code    = last_word;
               return 1'b1;
            end
            return 1'b0;
         end
         MODE_REP_GAP: begin
            if (in_window(t, windows.rep_gap_min, windows.rep_gap_max)) begin
               mode = MODE_REP_LEAD;
            end else begin
               enter_leader(t);
            end
            return 1'b0;
         end
         MODE_REP_LEAD: begin
            if (in_window(t, windows.rep_lead_min, windows.rep_lead_max)) begin
               mode    = MODE_REP_GAP;
               ev.kind = EVENT_REPEAT;
               ev.code = last_word;
               return 1'b1;
            end
            enter_leader(t);
            return 1'b0;
         end
         default: begin
            enter_leader(t);
            return 1'b0;
         end
      endcase
   endfunction

   // All channels are sampled at the rising edge; events are checked before
   // the interval of the same edge is predicted, as an event passes the result register.
   always @(posedge clock) begin
      ir_event_type fresh;
      ir_event_type oldest;
      if (reset) begin
         windows = '{leader_min:   RST_LEADER_MIN,
                     leader_max:   RST_LEADER_MAX,
                     one_thresh:   RST_ONE_THRESH,
                     rep_gap_min:  RST_REP_GAP_MIN,
                     rep_gap_max:  RST_REP_GAP_MAX,
                     rep_lead_min: RST_REP_LEAD_MIN,
                     rep_lead_max: RST_REP_LEAD_MAX};
         mode       = MODE_IDLE;
         bit_count  = '0;
         shift_bits = '0;
         last_word  = '0;
         owed_events.delete();
      end else begin
         // Event transfer against the oldest owed event.
         if (rsp_valid && !rsp_stall) begin
            if (owed_events.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("checker: unexpected event at %0t ns: kind %0d code %08h",
                           $time, rsp_event_kind, rsp_code_word);
               end
            end else begin
               oldest = owed_events.pop_front();
               if (rsp_event_kind !== oldest.kind || rsp_code_word !== oldest.code) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display({"checker: event mismatch at %0t ns: kind exp %0d got %0d,",
                               " code exp %08h got %08h"},
                              $time, oldest.kind, rsp_event_kind,
                              oldest.code, rsp_code_word);
                  end
               end
            end
         end

         // Interval transfer into the predictor.
         if (req_valid && !req_stall) begin
            if (decode_interval(req_interval_us, fresh)) begin
               owed_events.push_back(fresh);
            end
         end

         // Register write; an index past the list is dropped.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_LEADER_MIN:   windows.leader_min   = csr_data;
               REG_LEADER_MAX:   windows.leader_max   = csr_data;
               REG_ONE_THRESH:   windows.one_thresh   = csr_data;
               REG_REP_GAP_MIN:  windows.rep_gap_min  = csr_data;
               REG_REP_GAP_MAX:  windows.rep_gap_max  = csr_data;
               REG_REP_LEAD_MIN: windows.rep_lead_min = csr_data;
               REG_REP_LEAD_MAX: windows.rep_lead_max = csr_data;
               default: ;
            endcase
         end
      end

      events_owed <= owed_events.size();
      fail_count  <= error_count + (run_done ? owed_events.size() : 0);
   end

endmodule

[test/nec_ir_interval_decoder_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_interval_decoder_core_tb: testbench of the NEC interval decoder
// Drives falling-edge intervals under several sets of timing windows: a
// short directed run on the window edges, then random frames, repeat bursts,
// broken sequences and noise, with random idling on both channels, a long
// receiver hold-off and drains between phases. A checker beside the block
// predicts and compares every event.
// ----------------------------------------------------------------------------
module nec_ir_interval_decoder_core_tb;
   import nir_pkg::*;

   localparam int unsigned FRAME_BITS    = 32;
   localparam int unsigned NUM_WINDOWS   = 7;
   localparam int unsigned TIME_MAX      = (1 << TIME_W) - 1;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned PHASE_ITEMS   = 160;
   localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [TIME_W-1:0]  req_interval_us = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic               rsp_event_kind;
   logic [CODE_W-1:0]  rsp_code_word;
   logic               csr_valid       = 1'b0;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index       = '0;
   logic [TIME_W-1:0]  csr_data        = '0;
   logic               run_done        = 1'b0;
   int unsigned        events_owed;
   int unsigned        fail_count;

   // Testbench view of the windows, used to aim the stimulus.
   logic [TIME_W-1:0]  window_cfg [NUM_WINDOWS];
   logic               calm          = 1'b0;
   int unsigned        items_sent    = 0;
   int unsigned        hold_requests = 0;
   int unsigned        holds_served  = 0;

   always #1 clock = ~clock;

   nec_ir_interval_decoder_core #(
      .FRAME_BITS(FRAME_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_interval_us (req_interval_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_code_word   (rsp_code_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   nec_ir_interval_decoder_checker #(
      .FRAME_BITS(FRAME_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_interval_us (req_interval_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_code_word   (rsp_code_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .run_done        (run_done),
      .events_owed     (events_owed),
      .fail_count      (fail_count)
   );

   // Receiver: random stalls, with a long counted hold-off on request.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 35);
      end
   end

   // Guard against a hung handshake.
   initial begin
      #400000;
      $display("nec_ir_interval_decoder_core_tb: FAIL");
      $finish;
   end

   // One interval transfer, followed at random by an idle gap.
   task automatic send_interval(input logic [TIME_W-1:0] t);
      req_valid       <= 1'b1;
      req_interval_us <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(($urandom_range(9) == 0) ? 12 : 3, 1)) @(posedge clock);
      end
   endtask

   // Lets every owed event arrive, then lets the pipeline settle.
   task automatic wait_for_events();
      req_valid <= 1'b0;
      do @(posedge clock); while (events_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write transfer; the caller lowers the valid.
   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_windows();
      int i;
      for (i = 0; i < NUM_WINDOWS; i++) begin
         write_reg(INDEX_W'(i), window_cfg[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic randomise_windows();
      window_cfg[REG_LEADER_MIN]   = TIME_W'($urandom_range(14000, 8000));
      window_cfg[REG_LEADER_MAX]   = window_cfg[REG_LEADER_MIN] + TIME_W'($urandom_range(4000, 2));
      window_cfg[REG_ONE_THRESH]   = TIME_W'($urandom_range(3000, 500));
      window_cfg[REG_REP_GAP_MIN]  = TIME_W'($urandom_range(40000, 15000));
      window_cfg[REG_REP_GAP_MAX]  = window_cfg[REG_REP_GAP_MIN] + TIME_W'($urandom_range(90000, 2));
      window_cfg[REG_REP_LEAD_MIN] = TIME_W'($urandom_range(10000, 5000));
      window_cfg[REG_REP_LEAD_MAX] = window_cfg[REG_REP_LEAD_MIN] + TIME_W'($urandom_range(6000, 2));
   endtask

   // A value strictly inside (lo, hi), often on its edges; anything at all
   // when the window is empty.
   function automatic logic [TIME_W-1:0] pick_inside(input int unsigned lo, input int unsigned hi);
      if (hi <= lo + 1) return TIME_W'($urandom_range(TIME_MAX, 0));
      case ($urandom_range(9))
         0: return TIME_W'(lo + 1);
         1: return TIME_W'(hi - 1);
         default: return TIME_W'($urandom_range(hi - 1, lo + 1));
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] pick_outside(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(3))
         0: return TIME_W'(lo);
         1: return TIME_W'(hi);
         2: return TIME_W'($urandom_range(lo, 0));
         default: return TIME_W'($urandom_range(TIME_MAX, hi));
      endcase
   endfunction

   // A data interval for the wanted bit, near the threshold, or plain noise.
   function automatic logic [TIME_W-1:0] pick_data(input logic one);
      int unsigned thr;
      int unsigned span;
      thr = window_cfg[REG_ONE_THRESH];
      if ($urandom_range(9) == 0) return TIME_W'($urandom_range(TIME_MAX, 0));
      if (one && thr < TIME_MAX) begin
         span = ($urandom_range(3) == 0) ? 0 : (TIME_MAX - thr - 1 < 1200 ? TIME_MAX - thr - 1 : 1200);
         return TIME_W'(thr + 1 + $urandom_range(span, 0));
      end
      span = ($urandom_range(3) == 0) ? 0 : (thr < 1200 ? thr : 1200);
      return TIME_W'(thr - $urandom_range(span, 0));
   endfunction

   task automatic send_frame(input int unsigned bits);
      int unsigned i;
      send_interval(pick_inside(window_cfg[REG_LEADER_MIN], window_cfg[REG_LEADER_MAX]));
      for (i = 0; i < bits; i++) begin
         send_interval(pick_data($urandom_range(1, 0)));
      end
   endtask

   // A repeat burst; a broken one misses either the gap or the lead window.
   task automatic send_repeat(input bit good);
      if (!good && $urandom_range(1)) begin
         send_interval(pick_outside(window_cfg[REG_REP_GAP_MIN], window_cfg[REG_REP_GAP_MAX]));
      end else begin
         send_interval(pick_inside(window_cfg[REG_REP_GAP_MIN], window_cfg[REG_REP_GAP_MAX]));
         if (good) begin
            send_interval(pick_inside(window_cfg[REG_REP_LEAD_MIN],
                                      window_cfg[REG_REP_LEAD_MAX]));
         end else begin
            send_interval(pick_outside(window_cfg[REG_REP_LEAD_MIN],
                                       window_cfg[REG_REP_LEAD_MAX]));
         end
      end
   endtask

   // Mostly well-formed frames with repeats; the rest noise and cut frames.
   task automatic run_random(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_frame(FRAME_BITS);
            repeat ($urandom_range(3, 0)) send_repeat(1'b1);
            if ($urandom_range(1)) send_repeat(1'b0);
         end else if (pick < 70) begin
            send_repeat(1'b1);
         end else if (pick < 85) begin
            repeat ($urandom_range(6, 1)) send_interval(TIME_W'($urandom_range(TIME_MAX, 0)));
         end else begin
            send_frame($urandom_range(FRAME_BITS - 1, 1));
         end
      end
   endtask

   initial begin
      int unsigned i;
      window_cfg[REG_LEADER_MIN]   = RST_LEADER_MIN;
      window_cfg[REG_LEADER_MAX]   = RST_LEADER_MAX;
      window_cfg[REG_ONE_THRESH]   = RST_ONE_THRESH;
      window_cfg[REG_REP_GAP_MIN]  = RST_REP_GAP_MIN;
      window_cfg[REG_REP_GAP_MAX]  = RST_REP_GAP_MAX;
      window_cfg[REG_REP_LEAD_MIN] = RST_REP_LEAD_MIN;
      window_cfg[REG_REP_LEAD_MAX] = RST_REP_LEAD_MAX;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed run on the reset windows: leader bounds and extremes are
      // rejected, then a frame with bits on both sides of the threshold.
      send_interval('0);
      send_interval(TIME_W'(TIME_MAX));
      send_interval(RST_LEADER_MIN);
      send_interval(RST_LEADER_MAX);
      send_interval(RST_LEADER_MIN + 1'b1);
      for (i = 0; i < FRAME_BITS; i++) begin
         case (i % 4)
            0: send_interval('0);
            1: send_interval(RST_ONE_THRESH);
            2: send_interval(RST_ONE_THRESH + 1'b1);
            default: send_interval(TIME_W'(TIME_MAX));
         endcase
      end
      // A good repeat burst, then one whose lead falls on the window edge
      // and is taken again as a leader.
      send_interval(RST_REP_GAP_MIN + 1'b1);
      send_interval(RST_REP_LEAD_MIN + 1'b1);
      send_interval(RST_REP_GAP_MAX - 1'b1);
      send_interval(RST_REP_LEAD_MAX);
      wait_for_events();

      // Reset windows, random traffic.
      run_random(PHASE_ITEMS);
      wait_for_events();

      // Random windows, with the receiver holding off for a long stretch.
      randomise_windows();
      load_windows();
      hold_requests++;
      run_random(PHASE_ITEMS);
      wait_for_events();

      // Widest windows and a zero threshold; the first half without idling.
      window_cfg[REG_LEADER_MIN]   = '0;
      window_cfg[REG_LEADER_MAX]   = TIME_W'(TIME_MAX);
      window_cfg[REG_ONE_THRESH]   = '0;
      window_cfg[REG_REP_GAP_MIN]  = '0;
      window_cfg[REG_REP_GAP_MAX]  = TIME_W'(TIME_MAX);
      window_cfg[REG_REP_LEAD_MIN] = '0;
      window_cfg[REG_REP_LEAD_MAX] = TIME_W'(TIME_MAX);
      load_windows();
      calm <= 1'b1;
      run_random(PHASE_ITEMS / 2);
      calm <= 1'b0;
      run_random(PHASE_ITEMS / 2);
      wait_for_events();

      // Top-end leader window, maximum threshold, an empty gap window and an
      // inverted lead window; a write past the list must change nothing.
      window_cfg[REG_LEADER_MIN]   = TIME_W'(TIME_MAX - 2);
      window_cfg[REG_LEADER_MAX]   = TIME_W'(TIME_MAX);
      window_cfg[REG_ONE_THRESH]   = TIME_W'(TIME_MAX);
      window_cfg[REG_REP_GAP_MIN]  = TIME_W'(50000);
      window_cfg[REG_REP_GAP_MAX]  = TIME_W'(50001);
      window_cfg[REG_REP_LEAD_MIN] = TIME_W'(20000);
      window_cfg[REG_REP_LEAD_MAX] = TIME_W'(100);
      for (i = 0; i < NUM_WINDOWS; i++) begin
         write_reg(INDEX_W'(i), window_cfg[i]);
      end
      write_reg(REG_SPARE, TIME_W'($urandom_range(TIME_MAX, 0)));
      csr_valid <= 1'b0;
      run_random(PHASE_ITEMS);
      wait_for_events();

      // Random windows with the leader opened down to zero and the lead window opened to the top.
      randomise_windows();
      window_cfg[REG_LEADER_MIN]   = '0;
      window_cfg[REG_REP_LEAD_MAX] = TIME_W'(TIME_MAX);
      load_windows();
      run_random(PHASE_ITEMS);
      wait_for_events();

      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("nec_ir_interval_decoder_core_tb: PASS");
      end else begin
         $display("nec_ir_interval_decoder_core_tb: FAIL");
      end
      $finish;
   end

endmodule
